// ----- design/apr_pkg.sv -----
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types and constants for the audio playback ring with prebuffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apr_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int FRAME_W        = 2 * SAMPLE_W;
	localparam int GAIN_W         = 16;
	localparam int LEVEL_W        = 13;
	localparam int PAD_W          = 5;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam int DEF_RING_DEPTH = 8192;
	localparam int DEF_PAD_FRAMES = 16;

	localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd256;
	localparam logic [LEVEL_W-1:0] PREBUF_RESET = 13'd7168;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_DRAIN = 2'd1,
		OP_BEGIN = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 1'b0,
		REG_PREBUF = 1'b1
	} reg_t;

	// per-word status passed from the control unit to the output pipeline
	typedef struct packed {
		logic               from_mem;
		logic               frame_valid;
		logic               accepted;
		logic               underrun;
		logic [LEVEL_W-1:0] level;
		logic               playing;
		logic               finished;
	} meta_t;

endpackage

// ----- design/apr_in_if.sv -----
// ----------------------------------------------------------------------------
// apr_in_if
// Command channel: operation code and mono sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apr_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [1:0]                           operation;
	logic signed [apr_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output operation, output sample, input ready);
	modport sink   (input valid, input operation, input sample, output ready);
endinterface

// ----- design/apr_out_if.sv -----
// ----------------------------------------------------------------------------
// apr_out_if
// Result channel: stereo frame and status for each command word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apr_out_if;
	logic                          valid;
	logic                          ready;
	logic [apr_pkg::FRAME_W-1:0]   frame;
	logic                          frame_valid;
	logic                          accepted;
	logic                          underrun;
	logic [apr_pkg::LEVEL_W-1:0]   level;
	logic                          playing;
	logic                          finished;

	modport source (output valid, output frame, output frame_valid, output accepted,
		output underrun, output level, output playing, output finished, input ready);
	modport sink   (input valid, input frame, input frame_valid, input accepted,
		input underrun, input level, input playing, input finished, output ready);
endinterface

// ----- design/audio_playback_ring_with_prebuffer_top.sv -----
// ----------------------------------------------------------------------------
// audio_playback_ring_with_prebuffer_top
// Mono sample ring with prebuffer threshold feeding a stereo serial audio
// transmitter. Takes one command word per cycle (push, drain tick, begin,
// end) unless the result channel holds it off, and returns one status word
// for each, in order. A result passes through the registered read of the
// sample store and then the output register. The sample store is a single
// RAM of RING_DEPTH x 16 with one write and one read port, and needs no
// clearing after reset. Pushes are scaled by the Q8.8 gain register before
// storage; the user must write gain and prebuffer level on the plain config
// port only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_playback_ring_with_prebuffer_top #(
	parameter int RING_DEPTH = apr_pkg::DEF_RING_DEPTH,
	parameter int PAD_FRAMES = apr_pkg::DEF_PAD_FRAMES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [apr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apr_pkg::CFG_DATA_W-1:0] cfg_data,
	apr_in_if.sink                         item,
	apr_out_if.source                      result
);

	localparam int PTR_W = $clog2(RING_DEPTH);

	logic                           fire;
	logic [apr_pkg::GAIN_W-1:0]     gain;
	logic [apr_pkg::SAMPLE_W-1:0]   scaled;
	logic                           wr_en, rd_en;
	logic [PTR_W-1:0]               wr_addr, rd_addr;
	logic [apr_pkg::SAMPLE_W-1:0]   rd_data;
	apr_pkg::meta_t                 meta;

	apr_pkg::meta_t                 meta_s1, meta_s2;
	logic                           valid_s1, valid_s2;
	logic [apr_pkg::FRAME_W-1:0]    frame_s2;
	logic                           adv_s1;

	assign adv_s1     = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv_s1;
	assign fire       = item.valid && item.ready;

	apr_scale u_scale (
		.sample (item.sample),
		.gain   (gain),
		.scaled (scaled)
	);

	apr_ctrl #(
		.RING_DEPTH (RING_DEPTH),
		.PAD_FRAMES (PAD_FRAMES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.operation (item.operation),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.gain      (gain),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.meta      (meta)
	);

	apr_ram #(
		.WIDTH (apr_pkg::SAMPLE_W),
		.DEPTH (RING_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (scaled),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read data stays put while stage 1 is stalled: the next read only
	// issues on a new drain word, which needs stage 1 to move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= fire;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			meta_s1 <= meta;
		end
		if (adv_s1) begin
			meta_s2  <= meta_s1;
			frame_s2 <= meta_s1.from_mem ? {rd_data, rd_data} : '0;
		end
	end

	assign result.valid       = valid_s2;
	assign result.frame       = frame_s2;
	assign result.frame_valid = meta_s2.frame_valid;
	assign result.accepted    = meta_s2.accepted;
	assign result.underrun    = meta_s2.underrun;
	assign result.level       = meta_s2.level;
	assign result.playing     = meta_s2.playing;
	assign result.finished    = meta_s2.finished;

endmodule

// ----- design/apr_ram.sv -----
// ----------------------------------------------------------------------------
// apr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/apr_scale.sv -----
// ----------------------------------------------------------------------------
// apr_scale
// Q8.8 gain: multiply, round half to even, saturate to 16 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apr_scale (
	input  logic signed [apr_pkg::SAMPLE_W-1:0] sample,
	input  logic        [apr_pkg::GAIN_W-1:0]   gain,
	output logic        [apr_pkg::SAMPLE_W-1:0] scaled
);

	localparam int PROD_W = apr_pkg::SAMPLE_W + apr_pkg::GAIN_W + 1;
	localparam int QUO_W  = PROD_W - 8;

	logic signed [PROD_W-1:0] prod;
	logic signed [QUO_W-1:0]  quo;
	logic        [7:0]        frac;
	logic                     round_up;
	logic signed [QUO_W:0]    rounded;

	always_comb begin
		prod     = $signed({1'b0, gain}) * $signed(PROD_W'(sample));
		quo      = prod[PROD_W-1:8];   // floor of the divide by 256
		frac     = prod[7:0];
		round_up = (frac > 8'd128) || ((frac == 8'd128) && quo[0]);
		rounded  = $signed({quo[QUO_W-1], quo}) + $signed({{QUO_W{1'b0}}, round_up});
		if (rounded > $signed((QUO_W+1)'(32767))) begin
			scaled = 16'h7FFF;
		end else if (rounded < $signed(-(QUO_W+1)'(32768))) begin
			scaled = 16'h8000;
		end else begin
			scaled = rounded[apr_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

// ----- design/apr_ctrl.sv -----
// ----------------------------------------------------------------------------
// apr_ctrl
// Ring pointers, fill count, playback state and configuration registers.
// Issues sample store writes for pushes and reads for drain ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apr_ctrl #(
	parameter int RING_DEPTH = apr_pkg::DEF_RING_DEPTH,
	parameter int PAD_FRAMES = apr_pkg::DEF_PAD_FRAMES
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               fire,
	input  logic [1:0]                         operation,
	input  logic                               cfg_we,
	input  logic [apr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [apr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [apr_pkg::GAIN_W-1:0]         gain,
	output logic                               wr_en,
	output logic [$clog2(RING_DEPTH)-1:0]      wr_addr,
	output logic                               rd_en,
	output logic [$clog2(RING_DEPTH)-1:0]      rd_addr,
	output apr_pkg::meta_t                     meta
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int CMP_W = (PTR_W > apr_pkg::LEVEL_W) ? PTR_W : apr_pkg::LEVEL_W;
	localparam logic [PTR_W-1:0]          LAST_PTR = PTR_W'(RING_DEPTH - 1);
	localparam logic [apr_pkg::PAD_W-1:0] PAD_LOAD = apr_pkg::PAD_W'(PAD_FRAMES);

	logic [PTR_W-1:0]            wp_q, rp_q, fill_q;
	logic [PTR_W-1:0]            wp_n, rp_n, fill_n;
	logic                        running_q, ending_q, running_n, ending_n;
	logic [apr_pkg::PAD_W-1:0]   pad_q, pad_n, pad_dec;
	logic [apr_pkg::GAIN_W-1:0]  gain_q;
	logic [apr_pkg::LEVEL_W-1:0] prebuf_q;
	logic [CMP_W-1:0]            fill_ext;
	logic                        full, empty;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		full      = (fill_q == LAST_PTR);
		empty     = (fill_q == '0);
		wp_n      = wp_q;
		rp_n      = rp_q;
		fill_n    = fill_q;
		running_n = running_q;
		ending_n  = ending_q;
		pad_n     = pad_q;
		pad_dec   = pad_q - apr_pkg::PAD_W'(pad_q != '0);
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		meta      = '0;
		case (apr_pkg::op_t'(operation))
			apr_pkg::OP_PUSH: begin
				if (!full) begin
					wr_en           = fire;
					wp_n            = next_ptr(wp_q);
					fill_n          = fill_q + PTR_W'(1);
					meta.accepted   = 1'b1;
				end
				if (!running_q && (CMP_W'(fill_n) >= CMP_W'(prebuf_q))) begin
					running_n = 1'b1;
				end
			end
			apr_pkg::OP_DRAIN: begin
				if (running_q) begin
					if (!empty) begin
						rd_en            = fire;
						rp_n             = next_ptr(rp_q);
						fill_n           = fill_q - PTR_W'(1);
						meta.from_mem    = 1'b1;
						meta.frame_valid = 1'b1;
					end else if (ending_q) begin
						// pad frames of silence, then stop and rewind
						meta.frame_valid = (pad_q != '0);
						pad_n            = pad_dec;
						if (pad_dec == '0) begin
							meta.finished = 1'b1;
							running_n     = 1'b0;
							ending_n      = 1'b0;
							wp_n          = '0;
							rp_n          = '0;
							fill_n        = '0;
						end
					end else begin
						meta.frame_valid = 1'b1;
						meta.underrun    = 1'b1;
					end
				end
			end
			apr_pkg::OP_BEGIN: begin
				running_n = 1'b0;
				ending_n  = 1'b0;
				pad_n     = '0;
				wp_n      = '0;
				rp_n      = '0;
				fill_n    = '0;
			end
			apr_pkg::OP_END: begin
				running_n = 1'b1;
				ending_n  = 1'b1;
				pad_n     = PAD_LOAD;
			end
			default: begin
				running_n = running_q;
			end
		endcase
		fill_ext     = CMP_W'(fill_n);
		meta.level   = fill_ext[apr_pkg::LEVEL_W-1:0];
		meta.playing = running_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			fill_q    <= '0;
			running_q <= 1'b0;
			ending_q  <= 1'b0;
			pad_q     <= '0;
		end else if (fire) begin
			wp_q      <= wp_n;
			rp_q      <= rp_n;
			fill_q    <= fill_n;
			running_q <= running_n;
			ending_q  <= ending_n;
			pad_q     <= pad_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= apr_pkg::GAIN_RESET;
			prebuf_q <= apr_pkg::PREBUF_RESET;
		end else if (cfg_we) begin
			case (apr_pkg::reg_t'(cfg_index))
				apr_pkg::REG_GAIN:   gain_q   <= cfg_data;
				apr_pkg::REG_PREBUF: prebuf_q <= cfg_data[apr_pkg::LEVEL_W-1:0];
				default:             gain_q   <= gain_q;
			endcase
		end
	end

	assign gain    = gain_q;
	assign wr_addr = wp_q;
	assign rd_addr = rp_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LAST_PTR)
		else $error("ring fill beyond capacity");

	a_ending_running: assert property (@(posedge clk) disable iff (!arst_n)
		ending_q |-> running_q)
		else $error("end pending while stopped");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store written and read by one word");

	a_finish_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && meta.finished) |=> (wp_q == '0) && (rp_q == '0) && !running_q)
		else $error("finish did not stop and rewind");

	a_underrun_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && meta.underrun) |=> (fill_q == '0) && $stable(rp_q))
		else $error("underrun with data buffered");

endmodule

// ----- dv/tb_audio_playback_ring_with_prebuffer_top.sv -----
// ----------------------------------------------------------------------------
// tb_audio_playback_ring_with_prebuffer_top
// Self-checking bench for the audio playback ring. Command words (push, drain
// tick, begin, end) are driven through the item channel. A local mirror of
// the ring, the gain scaling and the playback state predicts the status word
// of every accepted command. A single monitor compares each result word with
// the oldest prediction. Directed cases come first: idle drain, underrun,
// padding, push after end, repeated end, begin while playing, gain rounding,
// a full ring and one long receiver hold-off. Randomised utterances follow,
// with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_audio_playback_ring_with_prebuffer_top;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RING_SLOTS  = apr_pkg::DEF_RING_DEPTH;
	localparam logic [apr_pkg::LEVEL_W-1:0] FULL_FILL = apr_pkg::LEVEL_W'(RING_SLOTS - 1);

	typedef struct packed {
		logic [apr_pkg::FRAME_W-1:0] frame;
		logic                        frame_valid;
		logic                        accepted;
		logic                        underrun;
		logic [apr_pkg::LEVEL_W-1:0] level;
		logic                        playing;
		logic                        finished;
	} status_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_we;
	apr_pkg::reg_t                  cfg_index;
	logic [apr_pkg::CFG_DATA_W-1:0] cfg_data;

	apr_in_if  item_if ();
	apr_out_if result_if ();

	audio_playback_ring_with_prebuffer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_if),
		.result    (result_if)
	);

	// mirror of the block state
	logic [apr_pkg::SAMPLE_W-1:0] mirror_ring [RING_SLOTS];
	logic [apr_pkg::LEVEL_W-1:0]  wr_ptr;
	logic [apr_pkg::LEVEL_W-1:0]  rd_ptr;
	logic                         playing_q;
	logic                         ending_q;
	logic [apr_pkg::PAD_W-1:0]    pad_left;
	logic [apr_pkg::GAIN_W-1:0]   gain_q88;
	logic [apr_pkg::LEVEL_W-1:0]  start_level;

	status_t expected_status [$];

	int send_idle   = 0;
	int recv_idle   = 0;
	int hold_cycles = 0;
	int errors      = 0;
	int cycles      = 0;
	int words_sent  = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ring depth is exactly 2**LEVEL_W, so pointers and fill wrap naturally
	function automatic logic [apr_pkg::LEVEL_W-1:0] ring_fill();
		return wr_ptr - rd_ptr;
	endfunction

	// sample * gain / 256, round half to even, saturate
	function automatic logic [apr_pkg::SAMPLE_W-1:0] scale_sample(
		logic signed [apr_pkg::SAMPLE_W-1:0] s);
		longint prod;
		longint q;
		longint r;
		prod = longint'(s) * longint'(gain_q88);
		q    = prod >>> 8;
		r    = prod & 255;
		if (r > 128 || (r == 128 && (q & 1) != 0))
			q++;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return apr_pkg::SAMPLE_W'(q);
	endfunction

	function automatic status_t predict_status(apr_pkg::op_t op,
		logic signed [apr_pkg::SAMPLE_W-1:0] s);
		status_t st;
		logic [apr_pkg::SAMPLE_W-1:0] v;
		st = '0;
		case (op)
		apr_pkg::OP_PUSH: begin
			if (ring_fill() != FULL_FILL) begin
				mirror_ring[wr_ptr] = scale_sample(s);
				wr_ptr = wr_ptr + 1'b1;
				st.accepted = 1'b1;
			end
			if (!playing_q && ring_fill() >= start_level)
				playing_q = 1'b1;
		end
		apr_pkg::OP_DRAIN: begin
			if (playing_q) begin
				if (ring_fill() != 0) begin
					v = mirror_ring[rd_ptr];
					st.frame = {v, v};
					st.frame_valid = 1'b1;
					rd_ptr = rd_ptr + 1'b1;
				end else if (ending_q) begin
					if (pad_left != 0) begin
						st.frame_valid = 1'b1;
						pad_left = pad_left - 1'b1;
					end
					if (pad_left == 0) begin
						st.finished = 1'b1;
						playing_q = 1'b0;
						ending_q = 1'b0;
						wr_ptr = '0;
						rd_ptr = '0;
					end
				end else begin
					// underrun: silence, read pointer held
					st.frame_valid = 1'b1;
					st.underrun = 1'b1;
				end
			end
		end
		apr_pkg::OP_BEGIN: begin
			playing_q = 1'b0;
			ending_q = 1'b0;
			pad_left = '0;
			wr_ptr = '0;
			rd_ptr = '0;
		end
		default: begin
			ending_q = 1'b1;
			playing_q = 1'b1;
			pad_left = apr_pkg::PAD_W'(apr_pkg::DEF_PAD_FRAMES);
		end
		endcase
		st.level = ring_fill();
		st.playing = playing_q;
		return st;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// result monitor and receiver idling
	always @(posedge clk) begin
		status_t want;
		if (result_if.valid && result_if.ready) begin
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected word, expected none, actual frame %h level %h",
					$time, result_if.frame, result_if.level);
			end else begin
				want = expected_status.pop_front();
				check_field("frame", want.frame, result_if.frame);
				check_field("frame_valid", want.frame_valid, result_if.frame_valid);
				check_field("accepted", want.accepted, result_if.accepted);
				check_field("underrun", want.underrun, result_if.underrun);
				check_field("level", want.level, result_if.level);
				check_field("playing", want.playing, result_if.playing);
				check_field("finished", want.finished, result_if.finished);
			end
		end
		if (hold_cycles > 0) begin
			result_if.ready <= 1'b0;
			hold_cycles--;
		end else begin
			result_if.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_word(apr_pkg::op_t op, logic signed [apr_pkg::SAMPLE_W-1:0] s);
		while ($urandom_range(0, 99) < send_idle) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid     <= 1'b1;
		item_if.operation <= op;
		item_if.sample    <= s;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		expected_status.push_back(predict_status(op, s));
		words_sent++;
	endtask

	// wait until every word is back and the pipeline is quiet
	task automatic settle();
		item_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(apr_pkg::reg_t idx, logic [apr_pkg::CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == apr_pkg::REG_GAIN)
			gain_q88 = d;
		else
			start_level = d[apr_pkg::LEVEL_W-1:0];
		@(posedge clk);
	endtask

	function automatic logic [apr_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 19))
		0: return 16'h7FFF;
		1: return 16'h8000;
		2: return 16'h0000;
		3: return 16'hFFFF;
		4: return 16'h0001;
		default: return apr_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [apr_pkg::CFG_DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return 16'd256;
		4: return 16'd0;
		5: return 16'hFFFF;
		6: return 16'd128;
		7: return apr_pkg::CFG_DATA_W'($urandom_range(1, 511));
		default: return apr_pkg::CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [apr_pkg::CFG_DATA_W-1:0] pick_level();
		case ($urandom_range(0, 9))
		0: return 16'd0;
		1: return 16'd1;
		2: return 16'd8191;
		3: return apr_pkg::CFG_DATA_W'($urandom_range(0, 8191));
		default: return apr_pkg::CFG_DATA_W'($urandom_range(2, 24));
		endcase
	endfunction

	// reset settings: pushes wait below the prebuffer level until an end
	task automatic test_reset_settings();
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_PUSH, 16'sh7FFF);
		send_word(apr_pkg::OP_PUSH, 16'sh8000);
		send_word(apr_pkg::OP_PUSH, 16'shFFFF);
		send_word(apr_pkg::OP_END, rand_sample());
		send_word(apr_pkg::OP_PUSH, 16'sh1234);
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_END, rand_sample());
		while (playing_q)
			send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		settle();
	endtask

	task automatic test_underrun_and_begin();
		write_reg(apr_pkg::REG_PREBUF, 16'd0);
		send_word(apr_pkg::OP_PUSH, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_PUSH, rand_sample());
		send_word(apr_pkg::OP_PUSH, rand_sample());
		send_word(apr_pkg::OP_BEGIN, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_PUSH, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_BEGIN, rand_sample());
		settle();
	endtask

	// ties at gain 128 and 384, saturation at full-scale gain
	task automatic test_gain_rounding();
		logic [apr_pkg::CFG_DATA_W-1:0] gains [4];
		logic [apr_pkg::SAMPLE_W-1:0]   probes [6];
		gains  = '{16'd0, 16'hFFFF, 16'd128, 16'd384};
		probes = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h0003, 16'hFFFD};
		write_reg(apr_pkg::REG_PREBUF, 16'd1);
		foreach (gains[g]) begin
			write_reg(apr_pkg::REG_GAIN, gains[g]);
			send_word(apr_pkg::OP_BEGIN, rand_sample());
			foreach (probes[p])
				send_word(apr_pkg::OP_PUSH, probes[p]);
			repeat (6) send_word(apr_pkg::OP_DRAIN, rand_sample());
			settle();
		end
	endtask

	// fill to the one-free-slot limit, refuse, then wrap both pointers
	task automatic test_full_ring();
		send_idle = 0;
		recv_idle = 0;
		write_reg(apr_pkg::REG_PREBUF, 16'd8191);
		write_reg(apr_pkg::REG_GAIN, pick_gain());
		send_word(apr_pkg::OP_BEGIN, rand_sample());
		repeat (RING_SLOTS + 1) send_word(apr_pkg::OP_PUSH, rand_sample());
		repeat (10) send_word(apr_pkg::OP_DRAIN, rand_sample());
		repeat (5) send_word(apr_pkg::OP_PUSH, rand_sample());
		send_word(apr_pkg::OP_END, rand_sample());
		while (playing_q)
			send_word(apr_pkg::OP_DRAIN, rand_sample());
		send_word(apr_pkg::OP_DRAIN, rand_sample());
		settle();
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 10;
		write_reg(apr_pkg::REG_PREBUF, 16'd4);
		send_word(apr_pkg::OP_BEGIN, rand_sample());
		hold_cycles = 300;
		repeat (80) begin
			if ($urandom_range(0, 9) < 6)
				send_word(apr_pkg::OP_PUSH, rand_sample());
			else
				send_word(apr_pkg::OP_DRAIN, rand_sample());
		end
		send_word(apr_pkg::OP_END, rand_sample());
		while (playing_q)
			send_word(apr_pkg::OP_DRAIN, rand_sample());
		settle();
	endtask

	task automatic play_utterance();
		int n;
		int k;
		send_word(apr_pkg::OP_BEGIN, rand_sample());
		n = $urandom_range(1, 48);
		repeat (n) begin
			k = $urandom_range(0, 99);
			if (k < 55)
				send_word(apr_pkg::OP_PUSH, rand_sample());
			else if (k < 88)
				send_word(apr_pkg::OP_DRAIN, rand_sample());
			else if (k < 93)
				send_word(apr_pkg::OP_END, rand_sample());
			else if (k < 96)
				send_word(apr_pkg::OP_BEGIN, rand_sample());
			else
				send_word(apr_pkg::op_t'($urandom_range(0, 3)), rand_sample());
		end
		send_word(apr_pkg::OP_END, rand_sample());
		if ($urandom_range(0, 3) == 0)
			send_word(apr_pkg::OP_PUSH, rand_sample());
		while (playing_q)
			send_word(apr_pkg::OP_DRAIN, rand_sample());
		repeat ($urandom_range(0, 2)) send_word(apr_pkg::OP_DRAIN, rand_sample());
	endtask

	task automatic test_random_traffic(int s_idle, int r_idle, int target);
		int first;
		send_idle = s_idle;
		recv_idle = r_idle;
		first = words_sent;
		while (words_sent - first < target) begin
			if ($urandom_range(0, 2) == 0) begin
				settle();
				write_reg(apr_pkg::REG_GAIN, pick_gain());
				write_reg(apr_pkg::REG_PREBUF, pick_level());
			end
			play_utterance();
		end
		settle();
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = apr_pkg::REG_GAIN;
		cfg_data          = '0;
		item_if.valid     = 1'b0;
		item_if.operation = apr_pkg::OP_PUSH;
		item_if.sample    = '0;
		result_if.ready   = 1'b0;
		wr_ptr            = '0;
		rd_ptr            = '0;
		playing_q         = 1'b0;
		ending_q          = 1'b0;
		pad_left          = '0;
		gain_q88          = apr_pkg::GAIN_RESET;
		start_level       = apr_pkg::PREBUF_RESET;
		send_idle         = 38;
		recv_idle         = 78;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_settings();
		test_underrun_and_begin();
		test_gain_rounding();
		test_full_ring();
		test_backpressure();
		test_random_traffic(38, 78, 680);
		test_random_traffic(78, 38, 680);
		test_random_traffic(0, 0, 680);

		repeat (10) @(posedge clk);
		if (errors == 0 && expected_status.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
